// ===== sv/per_sensor_running_average_alarm_unit_assert.svh =====
// assertion macros for the per-sensor running average alarm unit
// used by psraa_table and the top level; no other dependencies
`ifndef PER_SENSOR_RUNNING_AVERAGE_ALARM_UNIT_ASSERT_SVH
`define PER_SENSOR_RUNNING_AVERAGE_ALARM_UNIT_ASSERT_SVH

// same-cycle implication
`define PSRAA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// fixed-latency implication
`define PSRAA_ASSERT_LAT(label, clk, rst_n, ante, n, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
		else $error("latency check failed");

`endif

// ===== sv/psraa_pkg.sv =====
// shared types and constants of the per-sensor running average alarm unit
// no dependencies
`timescale 1ns / 1ps

package psraa_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int WINDOW_LENGTH = 5;

	localparam int ID_W   = 16;
	localparam int ROOM_W = 16;
	localparam int TEMP_W = 16;
	localparam int TIME_W = 32;

	localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int USED_W = $clog2(TABLE_ENTRIES + 1);
	localparam int SLOT_W = $clog2(WINDOW_LENGTH);
	localparam int CNT_W  = $clog2(WINDOW_LENGTH + 1);

	// divide by the window length through a reciprocal multiply
	localparam int SUM_W       = TEMP_W + $clog2(WINDOW_LENGTH) + 1;
	localparam int RECIP_SHIFT = SUM_W + $clog2(WINDOW_LENGTH);
	localparam int RECIP_W     = SUM_W + 1;
	localparam int PROD_W      = SUM_W + RECIP_W;
	localparam int QUO_W       = TEMP_W + 1;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(
		((64'd1 << RECIP_SHIFT) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH));

	localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(WINDOW_LENGTH);
	localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(WINDOW_LENGTH - 1);
	localparam logic [USED_W-1:0] USED_MAX = USED_W'(TABLE_ENTRIES);

	typedef logic signed [TEMP_W-1:0] temp_t;
	typedef temp_t [WINDOW_LENGTH-1:0] window_t;

	localparam temp_t MIN_TEMP_RESET = 16'sd2560;
	localparam temp_t MAX_TEMP_RESET = 16'sd5120;

	typedef enum logic [2:0] {
		ST_REGISTERED = 3'd0,
		ST_FULL       = 3'd1,
		ST_UNKNOWN    = 3'd2,
		ST_FILLING    = 3'd3,
		ST_NORMAL     = 3'd4,
		ST_COLD       = 3'd5,
		ST_HOT        = 3'd6
	} status_t;

	typedef enum logic {
		REQ_REGISTER = 1'b0,
		REQ_MEASURE  = 1'b1
	} req_t;

	typedef enum logic {
		CFG_MIN_TEMP = 1'b0,
		CFG_MAX_TEMP = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		req_t              req_type;
		logic [ID_W-1:0]   sensor_tag;
		logic [ROOM_W-1:0] room_id;
		temp_t             temperature;
		logic [TIME_W-1:0] timestamp;
	} item_t;

	typedef struct packed {
		status_t           status;
		logic              calc;
		logic [ID_W-1:0]   sensor_tag;
		logic [ROOM_W-1:0] room_id;
		logic [TIME_W-1:0] last_time;
	} meta_t;

	typedef struct packed {
		status_t           status;
		logic [ID_W-1:0]   sensor_tag;
		logic [ROOM_W-1:0] room_id;
		temp_t             average;
		logic [TIME_W-1:0] last_time;
	} result_t;

	typedef struct packed {
		temp_t min_temp;
		temp_t max_temp;
	} limits_t;

endpackage

// ===== sv/psraa_table.sv =====
// sensor table: id match, registration, sample window and timestamp update
// depends on psraa_pkg and per_sensor_running_average_alarm_unit_assert.svh
`timescale 1ns / 1ps
`include "per_sensor_running_average_alarm_unit_assert.svh"

module psraa_table (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vld_s1,
	input  psraa_pkg::item_t   item_s1,
	output logic               vld_s2,
	output psraa_pkg::meta_t   meta_s2,
	output psraa_pkg::window_t win_s2
);
	import psraa_pkg::*;

	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [USED_W-1:0]        used_q;
	logic [ID_W-1:0]          sensor_q [TABLE_ENTRIES];
	logic [ROOM_W-1:0]        room_q   [TABLE_ENTRIES];
	logic [CNT_W-1:0]         count_q  [TABLE_ENTRIES];
	logic [TIME_W-1:0]        time_q   [TABLE_ENTRIES];
	window_t                  window_q [TABLE_ENTRIES];

	logic [TABLE_ENTRIES-1:0] hit;
	logic                     hit_any;
	logic [IDX_W-1:0]         hit_idx;
	logic                     table_full;
	logic [IDX_W-1:0]         wr_idx;
	logic [CNT_W-1:0]         cnt_rd;
	logic [CNT_W-1:0]         cnt_nx;
	window_t                  win_rd;
	window_t                  win_nx;
	logic                     full_nx;
	logic                     do_reg;
	logic                     do_meas;
	meta_t                    meta_nx;

	always_comb begin
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			hit[i] = valid_q[i] && (sensor_q[i] == item_s1.sensor_tag);
		end
	end

	// lowest matching entry
	always_comb begin
		hit_idx = '0;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (hit[i]) begin
				hit_idx = IDX_W'(i);
			end
		end
	end

	assign hit_any    = |hit;
	assign table_full = (used_q == USED_MAX);
	assign wr_idx     = hit_any ? hit_idx : used_q[IDX_W-1:0];

	assign cnt_rd  = count_q[hit_idx];
	assign win_rd  = window_q[hit_idx];
	assign full_nx = (cnt_rd >= CNT_LAST);
	assign cnt_nx  = full_nx ? CNT_FULL : cnt_rd + CNT_W'(1);

	always_comb begin
		win_nx = win_rd;
		if (cnt_rd == CNT_FULL) begin
			for (int k = 0; k < WINDOW_LENGTH - 1; k++) begin
				win_nx[k] = win_rd[k + 1];
			end
			win_nx[WINDOW_LENGTH - 1] = item_s1.temperature;
		end else begin
			win_nx[cnt_rd[SLOT_W-1:0]] = item_s1.temperature;
		end
	end

	assign do_reg  = vld_s1 && (item_s1.req_type == REQ_REGISTER)
		&& (hit_any || !table_full);
	assign do_meas = vld_s1 && (item_s1.req_type == REQ_MEASURE) && hit_any;

	always_comb begin
		meta_nx.status     = ST_UNKNOWN;
		meta_nx.calc       = 1'b0;
		meta_nx.sensor_tag = item_s1.sensor_tag;
		meta_nx.room_id    = '0;
		meta_nx.last_time  = '0;
		unique case (item_s1.req_type)
			REQ_REGISTER: begin
				if (hit_any || !table_full) begin
					meta_nx.status  = ST_REGISTERED;
					meta_nx.room_id = item_s1.room_id;
				end else begin
					meta_nx.status = ST_FULL;
				end
			end
			REQ_MEASURE: begin
				if (hit_any) begin
					meta_nx.room_id = room_q[hit_idx];
					if (full_nx) begin
						meta_nx.status    = ST_NORMAL;
						meta_nx.calc      = 1'b1;
						meta_nx.last_time = item_s1.timestamp;
					end else begin
						meta_nx.status    = ST_FILLING;
						meta_nx.last_time = time_q[hit_idx];
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			used_q  <= '0;
			vld_s2  <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
			if (do_reg) begin
				valid_q[wr_idx] <= 1'b1;
				if (!hit_any) begin
					used_q <= used_q + USED_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_reg) begin
			sensor_q[wr_idx] <= item_s1.sensor_tag;
			room_q[wr_idx]   <= item_s1.room_id;
			count_q[wr_idx]  <= '0;
			time_q[wr_idx]   <= '0;
		end
		if (do_meas) begin
			count_q[hit_idx]  <= cnt_nx;
			window_q[hit_idx] <= win_nx;
			if (full_nx) begin
				time_q[hit_idx] <= item_s1.timestamp;
			end
		end
		if (vld_s1) begin
			meta_s2 <= meta_nx;
			win_s2  <= win_nx;
		end
	end

	`PSRAA_ASSERT_IMPLY(a_valid_matches_used, clk, arst_n,
		1'b1, $countones(valid_q) == int'(used_q))
	`PSRAA_ASSERT_IMPLY(a_ids_unique, clk, arst_n, vld_s1, $onehot0(hit))
	`PSRAA_ASSERT_IMPLY(a_full_only_when_used_up, clk, arst_n,
		vld_s2 && meta_s2.status == ST_FULL, used_q == USED_MAX)

endmodule

// ===== sv/psraa_avg.sv =====
// window sum, divide by the window length and threshold verdict
// depends on psraa_pkg
`timescale 1ns / 1ps

module psraa_avg (
	input  logic               clk,
	input  logic               arst_n,
	input  psraa_pkg::limits_t lim,
	input  logic               vld_s2,
	input  psraa_pkg::meta_t   meta_s2,
	input  psraa_pkg::window_t win_s2,
	output logic               done_q,
	output psraa_pkg::result_t res_q
);
	import psraa_pkg::*;

	logic signed [SUM_W-1:0] sum_nx;
	logic [SUM_W-1:0]        mag_nx;
	logic [PROD_W-1:0]       prod_nx;
	logic [QUO_W-1:0]        avg_full;
	temp_t                   avg_nx;
	result_t                 res_nx;

	logic                    vld_s3;
	meta_t                   meta_s3;
	logic                    neg_s3;
	logic [SUM_W-1:0]        mag_s3;

	logic                    vld_s4;
	meta_t                   meta_s4;
	logic                    neg_s4;
	logic [QUO_W-1:0]        quo_s4;

	always_comb begin
		sum_nx = '0;
		for (int k = 0; k < WINDOW_LENGTH; k++) begin
			sum_nx = sum_nx + SUM_W'($signed(win_s2[k]));
		end
	end

	assign mag_nx = sum_nx[SUM_W-1] ? SUM_W'(-sum_nx) : SUM_W'(sum_nx);

	assign prod_nx = PROD_W'(mag_s3) * PROD_W'(RECIP);

	// truncation toward zero: divide the magnitude, then restore the sign
	assign avg_full = neg_s4 ? (~quo_s4 + QUO_W'(1)) : quo_s4;
	assign avg_nx   = avg_full[TEMP_W-1:0];

	always_comb begin
		res_nx.status     = meta_s4.status;
		res_nx.sensor_tag = meta_s4.sensor_tag;
		res_nx.room_id    = meta_s4.room_id;
		res_nx.last_time  = meta_s4.last_time;
		res_nx.average    = '0;
		if (meta_s4.calc) begin
			res_nx.average = avg_nx;
			priority if ($signed(avg_nx) < $signed(lim.min_temp)) begin
				res_nx.status = ST_COLD;
			end else if ($signed(avg_nx) > $signed(lim.max_temp)) begin
				res_nx.status = ST_HOT;
			end else begin
				res_nx.status = ST_NORMAL;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			done_q <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			meta_s3 <= meta_s2;
			neg_s3  <= sum_nx[SUM_W-1];
			mag_s3  <= mag_nx;
		end
		if (vld_s3) begin
			meta_s4 <= meta_s3;
			neg_s4  <= neg_s3;
			quo_s4  <= prod_nx[RECIP_SHIFT +: QUO_W];
		end
		if (vld_s4) begin
			res_q <= res_nx;
		end
	end

endmodule

// ===== sv/per_sensor_running_average_alarm_unit.sv =====
// top level of the per-sensor running average alarm unit: ports, input and config registers
// depends on psraa_pkg, psraa_table, psraa_avg and per_sensor_running_average_alarm_unit_assert.svh
`timescale 1ns / 1ps
`include "per_sensor_running_average_alarm_unit_assert.svh"

// Takes one transaction per clock (busy never rises) and gives exactly one result per
// transaction, on done for a single cycle and in order, once it has passed the input, table,
// sum, multiply and result registers; the receiver cannot stall, so results must be captured
// when done is high. The sensor table is read and updated in the cycle after acceptance, so
// back-to-back transactions to the same sensor see each other's updates. The window sum, the
// reciprocal multiply for the division and the threshold compare follow in three more
// register stages. Thresholds may be written only while no transaction is in flight.
module per_sensor_running_average_alarm_unit (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	output logic                                    busy,
	input  logic                                    req_type,
	input  logic [psraa_pkg::ID_W-1:0]              sensor_tag,
	input  logic [psraa_pkg::ROOM_W-1:0]            room_id,
	input  logic signed [psraa_pkg::TEMP_W-1:0]     temperature,
	input  logic [psraa_pkg::TIME_W-1:0]            timestamp,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic                                    cfg_index,
	input  logic [psraa_pkg::TEMP_W-1:0]            cfg_data,
	output logic                                    done,
	output logic [$bits(psraa_pkg::status_t)-1:0]   status,
	output logic [psraa_pkg::ID_W-1:0]              out_sensor_tag,
	output logic [psraa_pkg::ROOM_W-1:0]            out_room_id,
	output logic signed [psraa_pkg::TEMP_W-1:0]     average,
	output logic [psraa_pkg::TIME_W-1:0]            last_time
);
	import psraa_pkg::*;

	localparam int LATENCY = 5;

	logic    vld_s1;
	item_t   item_s1;
	limits_t lim_q;
	logic    vld_s2;
	meta_t   meta_s2;
	window_t win_s2;
	logic    done_q;
	result_t res_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1         <= 1'b0;
			lim_q.min_temp <= MIN_TEMP_RESET;
			lim_q.max_temp <= MAX_TEMP_RESET;
		end else begin
			vld_s1 <= start && !busy;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_reg_t'(cfg_index))
					CFG_MIN_TEMP: lim_q.min_temp <= cfg_data;
					CFG_MAX_TEMP: lim_q.max_temp <= cfg_data;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_s1.req_type    <= req_t'(req_type);
			item_s1.sensor_tag  <= sensor_tag;
			item_s1.room_id     <= room_id;
			item_s1.temperature <= temperature;
			item_s1.timestamp   <= timestamp;
		end
	end

	psraa_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_s1  (vld_s1),
		.item_s1 (item_s1),
		.vld_s2  (vld_s2),
		.meta_s2 (meta_s2),
		.win_s2  (win_s2)
	);

	psraa_avg u_avg (
		.clk     (clk),
		.arst_n  (arst_n),
		.lim     (lim_q),
		.vld_s2  (vld_s2),
		.meta_s2 (meta_s2),
		.win_s2  (win_s2),
		.done_q  (done_q),
		.res_q   (res_q)
	);

	assign done           = done_q;
	assign status         = res_q.status;
	assign out_sensor_tag = res_q.sensor_tag;
	assign out_room_id    = res_q.room_id;
	assign average        = res_q.average;
	assign last_time      = res_q.last_time;

	`PSRAA_ASSERT_LAT(a_result_latency, clk, arst_n, start && !busy, LATENCY, done)
	`PSRAA_ASSERT_IMPLY(a_result_has_source, clk, arst_n, done, $past(start && !busy, LATENCY))
	`PSRAA_ASSERT_IMPLY(a_miss_gives_zeros, clk, arst_n,
		done && (status == ST_UNKNOWN || status == ST_FULL),
		out_room_id == '0 && average == '0 && last_time == '0)

endmodule
